// ===== hdl/ctr_pkg.sv =====
// Shared definitions for the chunked transfer reassembler.
// Command codes, fixed field widths and the controller/datapath link types.
// No dependencies.
package ctr_pkg;

  localparam int CMD_W     = 2;
  localparam int HASH_W    = 64;
  localparam int FIELD_W   = 16;
  localparam int BYTE_W    = 8;
  localparam int CNT_OUT_W = 7;
  localparam int LEN_OUT_W = 17;

  localparam logic [CMD_W-1:0] CMD_EXPECT = 2'd0;
  localparam logic [CMD_W-1:0] CMD_HEADER = 2'd1;
  localparam logic [CMD_W-1:0] CMD_DATA   = 2'd2;
  localparam logic [CMD_W-1:0] CMD_READ   = 2'd3;

  // controller to datapath
  typedef struct packed {
    logic exec;     // item accepted this cycle: update state, load result
    logic rd_load;  // store read data is ready: load it into the result
  } ctr_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic is_read;  // presented item is a store read
  } ctr_stat_t;

endpackage

// ===== hdl/chunked_transfer_reassembler.sv =====
// Top level of the chunked transfer reassembler.
// Instantiates ctr_ctrl and ctr_datapath; depends on ctr_pkg.
//
//   channel  direction  handshake                 payload
//   in       sink       in_valid_i / in_stall_o   cmd, hash, chunk fields, data, address
//   out      source     out_valid_o / out_stall_i accepted, done, counts, length, read data
//
// Expect, header and data items load their result as they are accepted; a read item
// holds input in a wait state for the registered read port of the byte store.
// The result register lets the next item in while a result is being taken.
// Reset clears progress and the expected hash; the byte store is not cleared and
// needs no pass after reset (unwritten bytes read as undefined).
// A stalled result holds, and input is stalled until the result slot can drain.
module chunked_transfer_reassembler #(
  parameter int CHUNK_BYTES = 1024,
  parameter int MAX_CHUNKS  = 64,
  parameter int MAX_BYTES   = 65536
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             in_valid_i,
  output logic                             in_stall_o,
  input  logic [ctr_pkg::CMD_W-1:0]        cmd_i,
  input  logic [ctr_pkg::HASH_W-1:0]       hash_i,
  input  logic [ctr_pkg::FIELD_W-1:0]      chunk_index_i,
  input  logic [ctr_pkg::FIELD_W-1:0]      chunk_count_i,
  input  logic [ctr_pkg::FIELD_W-1:0]      chunk_length_i,
  input  logic [ctr_pkg::BYTE_W-1:0]       data_byte_i,
  input  logic [ctr_pkg::FIELD_W-1:0]      read_address_i,
  output logic                             out_valid_o,
  input  logic                             out_stall_i,
  output logic                             accepted_o,
  output logic                             done_res_o,
  output logic [ctr_pkg::CNT_OUT_W-1:0]    chunks_received_o,
  output logic [ctr_pkg::CNT_OUT_W-1:0]    locked_count_o,
  output logic [ctr_pkg::LEN_OUT_W-1:0]    assembled_length_o,
  output logic [ctr_pkg::BYTE_W-1:0]       read_data_o
);
  import ctr_pkg::*;

  ctr_cmd_t  ctl_cmd;
  ctr_stat_t dp_stat;

  ctr_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .stat_i      (dp_stat),
    .cmd_o       (ctl_cmd)
  );

  ctr_datapath #(
    .CHUNK_BYTES (CHUNK_BYTES),
    .MAX_CHUNKS  (MAX_CHUNKS),
    .MAX_BYTES   (MAX_BYTES)
  ) u_datapath (
    .clk_i              (clk_i),
    .rst_ni             (rst_ni),
    .cmd_i              (ctl_cmd),
    .stat_o             (dp_stat),
    .cmd_in_i           (cmd_i),
    .hash_i             (hash_i),
    .chunk_index_i      (chunk_index_i),
    .chunk_count_i      (chunk_count_i),
    .chunk_length_i     (chunk_length_i),
    .data_byte_i        (data_byte_i),
    .read_address_i     (read_address_i),
    .accepted_o         (accepted_o),
    .done_res_o         (done_res_o),
    .chunks_received_o  (chunks_received_o),
    .locked_count_o     (locked_count_o),
    .assembled_length_o (assembled_length_o),
    .read_data_o        (read_data_o)
  );

endmodule

// ===== hdl/ctr_ram.sv =====
// Generic single-port RAM with registered read data.
// Holds the reassembly byte store. No dependencies.
module ctr_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 65536
) (
  input  logic                                   clk_i,
  input  logic                                   we_i,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] addr_i,
  input  logic [WIDTH-1:0]                       wdata_i,
  output logic [WIDTH-1:0]                       rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[addr_i] <= wdata_i;
    end
    rdata_o <= mem_q[addr_i];
  end

endmodule

// ===== hdl/ctr_ctrl.sv =====
// Controller of the reassembler: accept/issue sequencing and result valid.
// Depends on ctr_pkg for the command and status types.
module ctr_ctrl (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_stall_o,
  output logic                out_valid_o,
  input  logic                out_stall_i,
  input  ctr_pkg::ctr_stat_t  stat_i,
  output ctr_pkg::ctr_cmd_t   cmd_o
);
  import ctr_pkg::*;

  localparam logic S_IDLE = 1'b0;
  localparam logic S_READ = 1'b1;

  logic state_q, state_d;
  logic out_valid_q, out_valid_d;
  logic slot_free;

  // result slot is free if empty or being taken this cycle
  assign slot_free  = !out_valid_q || !out_stall_i;
  assign in_stall_o = (state_q != S_IDLE) || !slot_free;

  assign cmd_o.exec    = in_valid_i && !in_stall_o;
  assign cmd_o.rd_load = (state_q == S_READ);

  always_comb begin
    state_d = state_q;
    case (state_q)
      S_IDLE: begin
        if (cmd_o.exec && stat_i.is_read) begin
          state_d = S_READ;
        end
      end
      S_READ: begin
        state_d = S_IDLE;
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if ((cmd_o.exec && !stat_i.is_read) || cmd_o.rd_load) begin
      out_valid_d = 1'b1;
    end else if (!out_stall_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign out_valid_o = out_valid_q;

  a_read_slot_free : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_READ) |-> !out_valid_q)
    else $error("read data returned while result slot occupied");

  a_read_issue : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd_o.exec && stat_i.is_read) |=> (state_q == S_READ))
    else $error("store read issued without wait state");

  a_read_result : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_READ) |=> out_valid_q)
    else $error("read result not presented after wait state");

endmodule

// ===== hdl/ctr_datapath.sv =====
// Datapath of the reassembler: transfer progress, header checks, byte store
// and result registers. Depends on ctr_pkg and ctr_ram.
module ctr_datapath #(
  parameter int CHUNK_BYTES = 1024,
  parameter int MAX_CHUNKS  = 64,
  parameter int MAX_BYTES   = 65536
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  ctr_pkg::ctr_cmd_t                cmd_i,
  output ctr_pkg::ctr_stat_t               stat_o,
  input  logic [ctr_pkg::CMD_W-1:0]        cmd_in_i,
  input  logic [ctr_pkg::HASH_W-1:0]       hash_i,
  input  logic [ctr_pkg::FIELD_W-1:0]      chunk_index_i,
  input  logic [ctr_pkg::FIELD_W-1:0]      chunk_count_i,
  input  logic [ctr_pkg::FIELD_W-1:0]      chunk_length_i,
  input  logic [ctr_pkg::BYTE_W-1:0]       data_byte_i,
  input  logic [ctr_pkg::FIELD_W-1:0]      read_address_i,
  output logic                             accepted_o,
  output logic                             done_res_o,
  output logic [ctr_pkg::CNT_OUT_W-1:0]    chunks_received_o,
  output logic [ctr_pkg::CNT_OUT_W-1:0]    locked_count_o,
  output logic [ctr_pkg::LEN_OUT_W-1:0]    assembled_length_o,
  output logic [ctr_pkg::BYTE_W-1:0]       read_data_o
);
  import ctr_pkg::*;

  localparam int CNT_W = $clog2(MAX_CHUNKS + 1);
  localparam int IDX_W = (MAX_CHUNKS > 1) ? $clog2(MAX_CHUNKS) : 1;
  localparam int LEN_W = $clog2(MAX_BYTES + 1);
  localparam int AW    = (MAX_BYTES > 1) ? $clog2(MAX_BYTES) : 1;

  logic [HASH_W-1:0]     exp_hash_q, exp_hash_d;
  logic [MAX_CHUNKS-1:0] have_q, have_d;
  logic [CNT_W-1:0]      rcv_q, rcv_d;
  logic [CNT_W-1:0]      lock_q, lock_d;
  logic [LEN_W-1:0]      end_len_q, end_len_d;
  logic                  cmpl_q, cmpl_d;
  logic                  open_q, open_d;
  logic [LEN_W-1:0]      wptr_q, wptr_d;
  logic [FIELD_W-1:0]    left_q, left_d;
  logic                  rd_ok_q;

  logic                  acc;
  logic                  ram_we;
  logic [AW-1:0]         ram_addr;
  logic [BYTE_W-1:0]     ram_rdata;

  logic [IDX_W-1:0]      idx_sel;
  logic [31:0]           at_w, end_w, ra_w, rcv_ext, lock_ext, end_ext;
  logic                  hash_ok, cnt_over, lock_bad, hdr_ok, data_ok, rd_ok;

  assign stat_o.is_read = (cmd_in_i == CMD_READ);

  // header checks, in order of precedence
  assign idx_sel  = chunk_index_i[IDX_W-1:0];
  assign at_w     = 32'(chunk_index_i) * 32'(CHUNK_BYTES);
  assign end_w    = at_w + 32'(chunk_length_i);
  assign hash_ok  = (hash_i == exp_hash_q);
  assign cnt_over = 32'(chunk_count_i) > 32'(MAX_CHUNKS);
  assign lock_bad = (lock_q != '0) && (32'(lock_q) != 32'(chunk_count_i));
  assign hdr_ok   = (chunk_index_i < chunk_count_i)
                 && (end_w <= 32'(MAX_BYTES))
                 && !((17'(chunk_index_i) + 17'd1 < 17'(chunk_count_i))
                      && (32'(chunk_length_i) != 32'(CHUNK_BYTES)));

  assign data_ok  = open_q && (left_q != '0) && (32'(wptr_q) < 32'(MAX_BYTES));

  assign ra_w     = 32'(read_address_i);
  assign rd_ok    = ra_w < 32'(MAX_BYTES);
  assign ram_addr = stat_o.is_read ? ra_w[AW-1:0] : wptr_q[AW-1:0];

  always_comb begin
    exp_hash_d = exp_hash_q;
    have_d     = have_q;
    rcv_d      = rcv_q;
    lock_d     = lock_q;
    end_len_d  = end_len_q;
    cmpl_d     = cmpl_q;
    open_d     = open_q;
    wptr_d     = wptr_q;
    left_d     = left_q;
    acc        = 1'b0;
    ram_we     = 1'b0;
    if (cmd_i.exec) begin
      case (cmd_in_i)
        CMD_EXPECT: begin
          // same transfer still incomplete: leave progress alone
          if (!(hash_ok && !cmpl_q)) begin
            exp_hash_d = hash_i;
            have_d     = '0;
            rcv_d      = '0;
            lock_d     = '0;
            end_len_d  = '0;
            cmpl_d     = 1'b0;
            open_d     = 1'b0;
            wptr_d     = '0;
            left_d     = '0;
          end
        end
        CMD_HEADER: begin
          open_d = 1'b0;
          left_d = '0;
          if (hash_ok && !cnt_over && !lock_bad) begin
            // lock the count even if the remaining checks fail
            lock_d = CNT_W'(chunk_count_i);
            if (hdr_ok) begin
              acc = 1'b1;
              if (!have_q[idx_sel]) begin
                have_d[idx_sel] = 1'b1;
                rcv_d           = rcv_q + CNT_W'(1);
              end
              if (end_w > 32'(end_len_q)) begin
                end_len_d = LEN_W'(end_w);
              end
              cmpl_d = (rcv_d == CNT_W'(chunk_count_i));
              wptr_d = LEN_W'(at_w);
              left_d = chunk_length_i;
              open_d = (chunk_length_i != '0);
            end
          end
        end
        CMD_DATA: begin
          if (data_ok) begin
            ram_we = 1'b1;
            acc    = 1'b1;
            wptr_d = wptr_q + LEN_W'(1);
            left_d = left_q - FIELD_W'(1);
            open_d = (left_q != FIELD_W'(1));
          end else begin
            open_d = 1'b0;
            left_d = '0;
          end
        end
        CMD_READ: begin
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      exp_hash_q <= '0;
      have_q     <= '0;
      rcv_q      <= '0;
      lock_q     <= '0;
      end_len_q  <= '0;
      cmpl_q     <= 1'b0;
      open_q     <= 1'b0;
      wptr_q     <= '0;
      left_q     <= '0;
    end else begin
      exp_hash_q <= exp_hash_d;
      have_q     <= have_d;
      rcv_q      <= rcv_d;
      lock_q     <= lock_d;
      end_len_q  <= end_len_d;
      cmpl_q     <= cmpl_d;
      open_q     <= open_d;
      wptr_q     <= wptr_d;
      left_q     <= left_d;
    end
  end

  ctr_ram #(
    .WIDTH (BYTE_W),
    .DEPTH (MAX_BYTES)
  ) u_store (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .addr_i  (ram_addr),
    .wdata_i (data_byte_i),
    .rdata_o (ram_rdata)
  );

  // counts are reported masked to the result field widths
  assign rcv_ext  = 32'(rcv_d);
  assign lock_ext = 32'(lock_d);
  assign end_ext  = 32'(end_len_d);

  always_ff @(posedge clk_i) begin
    if (cmd_i.exec) begin
      accepted_o         <= acc;
      done_res_o         <= cmpl_d && (lock_d != '0);
      chunks_received_o  <= rcv_ext[CNT_OUT_W-1:0];
      locked_count_o     <= lock_ext[CNT_OUT_W-1:0];
      assembled_length_o <= end_ext[LEN_OUT_W-1:0];
      read_data_o        <= '0;
      rd_ok_q            <= rd_ok;
    end
    if (cmd_i.rd_load) begin
      read_data_o <= rd_ok_q ? ram_rdata : '0;
    end
  end

  a_open_has_bytes : assert property (@(posedge clk_i) disable iff (!rst_ni)
    open_q |-> (left_q != '0))
    else $error("chunk open with no bytes left");

  a_rcv_le_lock : assert property (@(posedge clk_i) disable iff (!rst_ni)
    rcv_q <= lock_q)
    else $error("received count above locked count");

  a_chunk_in_bounds : assert property (@(posedge clk_i) disable iff (!rst_ni)
    open_q |-> (32'(wptr_q) + 32'(left_q) <= 32'(MAX_BYTES)))
    else $error("open chunk runs past the store bound");

endmodule
